[rtl/core/gradient_line_rasterizer_top_defines.svh]
// ----------------------------------------------------------------------------
// Gradient line rasterizer: assertion macros
// Shared property wrappers for the rasterizer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_LINE_RASTERIZER_TOP_DEFINES_SVH
`define GRADIENT_LINE_RASTERIZER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/glr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glr_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package glr_pkg;

    localparam int CH_W      = 8;   // color channel width
    localparam int NUM_CH    = 3;   // red, green, blue
    localparam int STEP_SH   = 4;   // one pixel is 16 Q12.4 units
    localparam int QW        = 33;  // ratio-squared quotient width
    localparam int RW        = 17;  // Q1.16 ratio width, up to 1.0
    localparam int QSW       = 5;   // per-step minor quotient, at most 16
    localparam int IT_W      = 6;   // divider step counter
    localparam int DIV_LAST  = QW - 1;
    localparam int PW        = CH_W + 1 + RW + 1; // blend product width

    localparam logic [RW-1:0] ONE_Q16 = 17'h10000;

    // datapath commands
    typedef struct packed {
        logic load;
        logic setup1;
        logic setup2;
        logic slope_step;
        logic walk_reset;
        logic walk_adv;
        logic square;
        logic sum;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic rec_fail;
        logic rec_clip;
        logic blend;
        logic out_load;
    } cmd_t;

    // datapath status
    typedef struct packed {
        logic l2_zero;
        logic slope_done;
        logic too_far;
        logic div_last;
        logic sqrt_last;
        logic r_over;
        logic k_max;
        logic k_last;
    } stat_t;

endpackage

[rtl/core/gradient_line_rasterizer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_line_rasterizer_top
// Line rasterizer with start-to-end color blending along the segment.
// ----------------------------------------------------------------------------
// One segment word in gives one pixel word per major-axis step, the last one
// marked by m_tlast and every word of a run cut at MAX_PIXELS marked by m_tuser.
// A segment is handled alone: s_tready is high only while the block is idle.
// Setup finds the per-pixel minor slope, then two passes run over the pixels.
// Each step of a pass runs the 33-step restoring divider and the 17-step
// square root that turn the squared distance into the Q1.16 ratio; output
// stalls can hold the emitting pass.
module gradient_line_rasterizer_top #(
    parameter int MAX_PIXELS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // start_x, start_y, end_x, end_y, start_red, start_green, start_blue,
    // end_red, end_green, end_blue
    input  logic [((4*COORD_BITS+48+7)/8)*8-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue
    output logic [((2*COORD_BITS+24+7)/8)*8-1:0] m_tdata,
    output logic                 m_tlast,
    // clipped
    output logic                 m_tuser
);

    `include "gradient_line_rasterizer_top_defines.svh"

    localparam int CW    = COORD_BITS;
    localparam int OUT_W = ((2*COORD_BITS+24+7)/8)*8;
    localparam int CH_W  = glr_pkg::CH_W;
    localparam int CB    = 4 * CW;

    glr_pkg::cmd_t  cmd;
    glr_pkg::stat_t stat;

    logic signed [CW-1:0] pixel_x, pixel_y;
    logic [CH_W-1:0]      start_c [glr_pkg::NUM_CH];
    logic [CH_W-1:0]      end_c   [glr_pkg::NUM_CH];
    logic [CH_W-1:0]      pixel_c [glr_pkg::NUM_CH];

    // unpack the color fields
    always_comb begin
        for (int i = 0; i < glr_pkg::NUM_CH; i++) begin
            start_c[i] = s_tdata[CB + CH_W*i +: CH_W];
            end_c[i]   = s_tdata[CB + CH_W*(i+3) +: CH_W];
        end
    end

    glr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    glr_datapath #(
        .MAX_PIXELS (MAX_PIXELS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .cmd        (cmd),
        .stat       (stat),
        .start_x    ($signed(s_tdata[CW-1:0])),
        .start_y    ($signed(s_tdata[2*CW-1:CW])),
        .end_x      ($signed(s_tdata[3*CW-1:2*CW])),
        .end_y      ($signed(s_tdata[4*CW-1:3*CW])),
        .start_c    (start_c),
        .end_c      (end_c),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_c    (pixel_c),
        .last_pixel (m_tlast),
        .clipped    (m_tuser)
    );

    // pack the pixel word, zero-filled to whole bytes
    assign m_tdata = OUT_W'({pixel_c[2], pixel_c[1], pixel_c[0], pixel_y, pixel_x});

    // one segment at a time: never ready while a pixel word is offered
    `GLR_ASSERT_IMP(a_ready_excl, aclk, aresetn, s_tready, !m_tvalid, "ready while emitting")
    // setup always takes cycles before the first pixel
    `GLR_ASSERT_NXT(a_no_early_out, aclk, aresetn, s_tvalid && s_tready, !m_tvalid, "early pixel")
    // the last pixel of a run returns the block to idle
    `GLR_ASSERT_NXT(a_last_idle, aclk, aresetn, m_tvalid && m_tready && m_tlast, s_tready, "no idle after last")

endmodule

[rtl/core/glr_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glr_datapath
// Segment registers, minor-axis stepper, squared distance, restoring divider,
// bit-serial square root and color blend for the line rasterizer.
// ----------------------------------------------------------------------------
module glr_datapath #(
    parameter int MAX_PIXELS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                          aclk,
    input  glr_pkg::cmd_t                 cmd,
    output glr_pkg::stat_t                stat,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    input  logic [glr_pkg::CH_W-1:0]      start_c [glr_pkg::NUM_CH],
    input  logic [glr_pkg::CH_W-1:0]      end_c   [glr_pkg::NUM_CH],
    output logic signed [COORD_BITS-1:0]  pixel_x,
    output logic signed [COORD_BITS-1:0]  pixel_y,
    output logic [glr_pkg::CH_W-1:0]      pixel_c [glr_pkg::NUM_CH],
    output logic                          last_pixel,
    output logic                          clipped
);

    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;
    localparam int LW   = 2 * CW + 2;
    localparam int KW   = $clog2(MAX_PIXELS + 1);
    localparam int MAGW = KW + glr_pkg::STEP_SH;
    localparam int SW   = 2 * MAGW;
    localparam int D2W  = SW + 1;
    localparam int SLW  = DW + glr_pkg::STEP_SH;
    localparam int CMPW = LW + D2W + 1;
    localparam int AW   = CW + MAGW + 1;
    localparam int QW   = glr_pkg::QW;

    // segment registers
    logic signed [CW-1:0]      sx_reg, sy_reg, ex_reg, ey_reg;
    logic [glr_pkg::CH_W-1:0]  ca_reg [glr_pkg::NUM_CH];
    logic [glr_pkg::CH_W-1:0]  cb_reg [glr_pkg::NUM_CH];

    // axis setup
    logic                      xmajor_reg, maj_neg_reg, min_neg_reg;
    logic [DW-1:0]             amaj_reg, amin_reg;
    logic [LW-1:0]             l2_reg;
    logic [SLW-1:0]            srem_reg;
    logic [glr_pkg::QSW-1:0]   qs_reg;

    // walk
    logic [KW-1:0]             k_reg, n_reg;
    logic                      clip_reg;
    logic [MAGW-1:0]           moq_reg;
    logic [DW-1:0]             mrem_reg;
    logic [SW-1:0]             msq_reg, mosq_reg;
    logic [D2W-1:0]            d2_reg;

    // divider and root
    logic [LW-1:0]             rem_reg;
    logic                      nb_reg;
    logic [QW-1:0]             q_reg;
    logic [glr_pkg::IT_W-1:0]  it_reg;
    logic [QW-1:0]             sn_reg, res_reg, sbit_reg;

    // blend
    logic signed [glr_pkg::PW-1:0] prod_reg [glr_pkg::NUM_CH];

    // combinational helpers
    logic signed [DW-1:0]      dx, dy;
    logic [DW-1:0]             adx, ady;
    logic                      xmaj;
    logic [DW:0]               madd;
    logic [MAGW-1:0]           mmag;
    logic [LW:0]               dtrial;
    logic                      dge;
    logic [QW:0]               strial;
    logic signed [MAGW:0]      off_maj, off_min, ox, oy;
    logic signed [AW-1:0]      px_sum, py_sum;

    // deltas from the captured segment
    assign dx   = DW'(ex_reg) - DW'(sx_reg);
    assign dy   = DW'(ey_reg) - DW'(sy_reg);
    assign adx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ady  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign xmaj = adx > ady;

    assign madd   = (DW+1)'(mrem_reg) + (DW+1)'(srem_reg);
    assign mmag   = MAGW'({k_reg, {glr_pkg::STEP_SH{1'b0}}});
    assign dtrial = {rem_reg, nb_reg};
    assign dge    = dtrial >= {1'b0, l2_reg};
    assign strial = (QW+1)'(res_reg) + (QW+1)'(sbit_reg);

    // signed offsets from the start point
    assign off_maj = maj_neg_reg ? -$signed({1'b0, mmag}) : $signed({1'b0, mmag});
    assign off_min = min_neg_reg ? -$signed({1'b0, moq_reg}) : $signed({1'b0, moq_reg});
    assign ox      = xmajor_reg ? off_maj : off_min;
    assign oy      = xmajor_reg ? off_min : off_maj;
    assign px_sum  = AW'(sx_reg) + AW'(ox);
    assign py_sum  = AW'(sy_reg) + AW'(oy);

    // status
    assign stat.l2_zero    = l2_reg == '0;
    assign stat.slope_done = srem_reg < SLW'(amaj_reg);
    assign stat.too_far    = CMPW'(d2_reg) >= (CMPW'(l2_reg) << 1);
    assign stat.div_last   = it_reg == '0;
    assign stat.sqrt_last  = sbit_reg[0];
    assign stat.r_over     = res_reg > QW'(glr_pkg::ONE_Q16);
    assign stat.k_max      = k_reg == KW'(MAX_PIXELS);
    assign stat.k_last     = k_reg == (n_reg - KW'(1));

    // segment capture and axis setup
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sx_reg   <= start_x;
            sy_reg   <= start_y;
            ex_reg   <= end_x;
            ey_reg   <= end_y;
            ca_reg   <= start_c;
            cb_reg   <= end_c;
            n_reg    <= KW'(1);
            clip_reg <= 1'b0;
        end
        if (cmd.setup1) begin
            xmajor_reg  <= xmaj;
            maj_neg_reg <= xmaj ? dx[DW-1] : dy[DW-1];
            min_neg_reg <= xmaj ? dy[DW-1] : dx[DW-1];
            amaj_reg    <= xmaj ? adx : ady;
            amin_reg    <= xmaj ? ady : adx;
        end
        if (cmd.setup2) begin
            l2_reg   <= LW'(amaj_reg * amaj_reg) + LW'(amin_reg * amin_reg);
            srem_reg <= {amin_reg, {glr_pkg::STEP_SH{1'b0}}};
            qs_reg   <= '0;
        end
        if (cmd.slope_step) begin
            srem_reg <= srem_reg - SLW'(amaj_reg);
            qs_reg   <= qs_reg + 1'b1;
        end
        if (cmd.rec_fail) begin
            n_reg <= k_reg;
        end
        if (cmd.rec_clip) begin
            n_reg    <= KW'(MAX_PIXELS);
            clip_reg <= 1'b1;
        end
    end

    // major-axis walk with running minor quotient and remainder, then squared distance
    always_ff @(posedge aclk) begin
        if (cmd.walk_reset) begin
            k_reg    <= '0;
            moq_reg  <= '0;
            mrem_reg <= '0;
        end else if (cmd.walk_adv) begin
            k_reg <= k_reg + 1'b1;
            if (madd >= (DW+1)'(amaj_reg)) begin
                mrem_reg <= DW'(madd - (DW+1)'(amaj_reg));
                moq_reg  <= moq_reg + MAGW'(qs_reg) + MAGW'(1);
            end else begin
                mrem_reg <= DW'(madd);
                moq_reg  <= moq_reg + MAGW'(qs_reg);
            end
        end
        if (cmd.square) begin
            msq_reg  <= mmag * mmag;
            mosq_reg <= moq_reg * moq_reg;
        end
        if (cmd.sum) begin
            d2_reg <= D2W'(msq_reg) + D2W'(mosq_reg);
        end
    end

    // restoring divider: q = floor(d2 * 2^32 / l2), known below 2^33
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= LW'(d2_reg >> 1);
            nb_reg  <= d2_reg[0];
            q_reg   <= '0;
            it_reg  <= glr_pkg::IT_W'(glr_pkg::DIV_LAST);
        end else if (cmd.div_step) begin
            rem_reg <= dge ? LW'(dtrial - {1'b0, l2_reg}) : LW'(dtrial);
            nb_reg  <= 1'b0;
            q_reg   <= {q_reg[QW-2:0], dge};
            it_reg  <= it_reg - 1'b1;
        end
    end

    // bit-pair square root, two quotient bits consumed per step
    always_ff @(posedge aclk) begin
        if (cmd.walk_reset) begin
            res_reg <= '0;
        end else if (cmd.sqrt_init) begin
            sn_reg   <= q_reg;
            res_reg  <= '0;
            sbit_reg <= QW'(1) << (QW - 1);
        end else if (cmd.sqrt_step) begin
            if ({1'b0, sn_reg} >= strial) begin
                sn_reg  <= sn_reg - QW'(strial);
                res_reg <= (res_reg >> 1) + sbit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
    end

    // color blend: c = a + floor((b - a) * r / 2^16)
    always_ff @(posedge aclk) begin
        if (cmd.blend) begin
            for (int i = 0; i < glr_pkg::NUM_CH; i++) begin
                prod_reg[i] <= glr_pkg::PW'(
                    ($signed({1'b0, cb_reg[i]}) - $signed({1'b0, ca_reg[i]}))
                    * $signed({1'b0, res_reg[glr_pkg::RW-1:0]}));
            end
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            pixel_x    <= CW'(px_sum);
            pixel_y    <= CW'(py_sum);
            last_pixel <= stat.k_last;
            clipped    <= clip_reg;
            for (int i = 0; i < glr_pkg::NUM_CH; i++) begin
                pixel_c[i] <= ca_reg[i] + prod_reg[i][23:16];
            end
        end
    end

endmodule

[rtl/core/glr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glr_ctrl
// Sequencer for the rasterizer: a counting pass that finds the run length and
// the clip flag, then an emitting pass that produces one word per pixel.
// ----------------------------------------------------------------------------
module glr_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  glr_pkg::stat_t stat,
    output glr_pkg::cmd_t  cmd
);

    typedef enum logic [15:0] {
        ST_IDLE   = 16'b0000_0000_0000_0001,
        ST_SETUP1 = 16'b0000_0000_0000_0010,
        ST_SETUP2 = 16'b0000_0000_0000_0100,
        ST_SLOPE  = 16'b0000_0000_0000_1000,
        ST_WALK0  = 16'b0000_0000_0001_0000,
        ST_ADV    = 16'b0000_0000_0010_0000,
        ST_SQ     = 16'b0000_0000_0100_0000,
        ST_SUM    = 16'b0000_0000_1000_0000,
        ST_CHK    = 16'b0000_0001_0000_0000,
        ST_DIV    = 16'b0000_0010_0000_0000,
        ST_SQI    = 16'b0000_0100_0000_0000,
        ST_SQRT   = 16'b0000_1000_0000_0000,
        ST_TEST   = 16'b0001_0000_0000_0000,
        ST_PASS2  = 16'b0010_0000_0000_0000,
        ST_BLEND  = 16'b0100_0000_0000_0000,
        ST_OUT    = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   emit_reg, emit_next;
    logic   wait_reg, wait_next;

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = wait_reg;

    // state and pass registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            emit_reg  <= 1'b0;
            wait_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
            wait_reg  <= wait_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        emit_next  = emit_reg;
        wait_next  = wait_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP1;
                end
            end
            ST_SETUP1: begin
                cmd.setup1 = 1'b1;
                state_next = ST_SETUP2;
            end
            ST_SETUP2: begin
                cmd.setup2 = 1'b1;
                state_next = ST_SLOPE;
            end
            ST_SLOPE: begin
                if (stat.l2_zero) begin
                    state_next = ST_PASS2;
                end else if (stat.slope_done) begin
                    state_next = ST_WALK0;
                end else begin
                    cmd.slope_step = 1'b1;
                end
            end
            ST_WALK0: begin
                cmd.walk_reset = 1'b1;
                emit_next      = 1'b0;
                state_next     = ST_ADV;
            end
            ST_ADV: begin
                cmd.walk_adv = 1'b1;
                state_next   = ST_SQ;
            end
            ST_SQ: begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (!emit_reg && stat.too_far) begin
                    cmd.rec_fail = 1'b1;
                    state_next   = ST_PASS2;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_SQI;
                end
            end
            ST_SQI: begin
                cmd.sqrt_init = 1'b1;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last) begin
                    state_next = emit_reg ? ST_BLEND : ST_TEST;
                end
            end
            ST_TEST: begin
                if (stat.r_over) begin
                    cmd.rec_fail = 1'b1;
                    state_next   = ST_PASS2;
                end else if (stat.k_max) begin
                    cmd.rec_clip = 1'b1;
                    state_next   = ST_PASS2;
                end else begin
                    state_next = ST_ADV;
                end
            end
            ST_PASS2: begin
                cmd.walk_reset = 1'b1;
                emit_next      = 1'b1;
                state_next     = ST_BLEND;
            end
            ST_BLEND: begin
                cmd.blend  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // load the word once, then hold it until taken
                if (!wait_reg) begin
                    cmd.out_load = 1'b1;
                    wait_next    = 1'b1;
                end else if (out_ready) begin
                    wait_next  = 1'b0;
                    state_next = stat.k_last ? ST_IDLE : ST_ADV;
                end
            end
            default: begin
                state_next = ST_IDLE;
                wait_next  = 1'b0;
            end
        endcase
    end

endmodule

[tb/tb_gradient_line_rasterizer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_line_rasterizer_top
// Self-checking bench for the gradient line rasterizer. Segments are offered
// from a queue by a clocked driver. Each accepted segment is expanded into
// its expected pixel words by a local line-walk and color-blend predictor.
// A clocked monitor checks every pixel word against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_gradient_line_rasterizer_top;

    localparam int CH_W      = glr_pkg::CH_W;
    localparam int NPIX      = 64;
    localparam int CW        = 16;
    localparam int STEP      = 16;
    localparam int WDOG_MAX  = 40000;
    localparam int HOLD_LEN  = 600;
    localparam int N_RANDOM  = 255;

    typedef struct {
        logic signed [CW-1:0] sx, sy, ex, ey;
        logic [CH_W-1:0]      sr, sg, sb, er, eg, eb;
        bit                   drain; // wait for all pixels before offering
    } seg_t;

    typedef struct {
        logic [CW-1:0]   x, y;
        logic [CH_W-1:0] r, g, b;
        logic            last, clip;
    } pix_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [111:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    seg_t segs_pending[$];
    pix_t pixels_due[$];
    seg_t seg_on_bus;
    int   segs_taken = 0;
    int   mismatches = 0;
    int   idle_cycles = 0;
    int   hold_cnt = 0;
    bit   hold_done = 0;

    gradient_line_rasterizer_top #(.MAX_PIXELS(NPIX), .COORD_BITS(CW)) dut (.*);

    initial forever #4 aclk = ~aclk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [CH_W-1:0] mix(logic [CH_W-1:0] a, logic [CH_W-1:0] c,
                                            longint unsigned r);
        longint unsigned t;
        t = (longint'(a) * (65536 - r) + longint'(c) * r) >> 16;
        return t[CH_W-1:0];
    endfunction

    // walk the major axis, queue one expected word per emitted pixel
    task automatic predict_pixels(seg_t s);
        longint sx, sy, dx, dy, adx, ady, dmaj, dmin, dir, m, mo, ox, oy;
        longint unsigned l2, d2, r;
        longint unsigned rat[NPIX];
        longint xs[NPIX], ys[NPIX];
        bit xmaj, clip;
        int n;
        pix_t p;
        sx = s.sx; sy = s.sy;
        dx = longint'(s.ex) - sx;
        dy = longint'(s.ey) - sy;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        xmaj = adx > ady;
        dmaj = xmaj ? dx : dy;
        dmin = xmaj ? dy : dx;
        dir = (dmaj < 0) ? -1 : 1;
        l2 = longint'(dx * dx) + longint'(dy * dy);
        n = 1; clip = 0;
        xs[0] = sx; ys[0] = sy; rat[0] = 0;
        if (l2 != 0) begin
            for (int k = 1; k <= NPIX; k++) begin
                m = dir * k * STEP;
                mo = (dmin * m) / dmaj;
                ox = xmaj ? m : mo;
                oy = xmaj ? mo : m;
                d2 = ox * ox + oy * oy;
                r = int_sqrt((d2 << 32) / l2);
                if (r > 65536) break;
                if (k == NPIX) begin
                    clip = 1;
                    break;
                end
                xs[k] = sx + ox; ys[k] = sy + oy; rat[k] = r;
                n = k + 1;
            end
        end
        for (int k = 0; k < n; k++) begin
            p.x = xs[k][CW-1:0];
            p.y = ys[k][CW-1:0];
            p.r = mix(s.sr, s.er, rat[k]);
            p.g = mix(s.sg, s.eg, rat[k]);
            p.b = mix(s.sb, s.eb, rat[k]);
            p.last = (k == n - 1);
            p.clip = clip;
            pixels_due.push_back(p);
        end
    endtask

    function automatic seg_t mk(int sx, int sy, int ex, int ey, bit rnd_color);
        seg_t s;
        s.sx = CW'(sx); s.sy = CW'(sy); s.ex = CW'(ex); s.ey = CW'(ey);
        s.sr = rnd_color ? CH_W'($urandom) : 8'd255;
        s.sg = rnd_color ? CH_W'($urandom) : 8'd0;
        s.sb = rnd_color ? CH_W'($urandom) : 8'd255;
        s.er = rnd_color ? CH_W'($urandom) : 8'd0;
        s.eg = rnd_color ? CH_W'($urandom) : 8'd255;
        s.eb = rnd_color ? CH_W'($urandom) : 8'd0;
        s.drain = 0;
        return s;
    endfunction

    // stimulus: directed corners, then random segments
    initial begin
        seg_t s;
        int maj, mnr, sx, sy, dx, dy;
        segs_pending.push_back(mk(100, 200, 100, 200, 0));       // equal endpoints
        segs_pending.push_back(mk(0, 0, 5, 3, 0));               // sub-pixel length
        segs_pending.push_back(mk(0, 0, 80, 0, 0));              // +x
        segs_pending.push_back(mk(37, -9, -43, -9, 1));          // -x, fractional
        segs_pending.push_back(mk(0, 0, 0, 80, 1));              // +y
        segs_pending.push_back(mk(5, 7, 0, -90, 1));             // -y, steep
        segs_pending.push_back(mk(0, 0, 96, 96, 1));             // tie: y major
        segs_pending.push_back(mk(0, 0, -96, 96, 1));            // tie, mixed sign
        segs_pending.push_back(mk(10, 20, 150, -53, 1));         // negative minor
        segs_pending.push_back(mk(0, 0, 1008, 0, 1));            // exactly max pixels
        segs_pending.push_back(mk(0, 0, 1024, 0, 1));            // just clipped
        segs_pending.push_back(mk(-32768, 0, 32767, 0, 0));      // x extremes
        segs_pending.push_back(mk(-1, 32767, -1, -32768, 1));    // y extremes
        segs_pending.push_back(mk(32767, 32767, -32768, -32768, 1));
        s = mk(32700, -32700, 32767, -32768, 0);                 // near the edge
        s.sr = 0; s.sg = 255; s.sb = 0; s.er = 255; s.eg = 0; s.eb = 255;
        segs_pending.push_back(s);
        s = mk(-500, 300, -300, 333, 1);
        s.drain = 1;
        segs_pending.push_back(s);
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 49) == 0) begin
                // full-range noise, usually clipped
                s = mk($urandom, $urandom, $urandom, $urandom, 1);
            end else begin
                maj = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 1100)
                                                    : $urandom_range(0, 200);
                mnr = $urandom_range(0, maj);
                if ($urandom_range(0, 1)) begin
                    dx = maj; dy = mnr;
                end else begin
                    dx = mnr; dy = maj;
                end
                if ($urandom_range(0, 1)) dx = -dx;
                if ($urandom_range(0, 1)) dy = -dy;
                sx = $urandom_range(0, 65535) - 32768;
                sy = $urandom_range(0, 65535) - 32768;
                if (sx + dx > 32767 || sx + dx < -32768) dx = -dx;
                if (sy + dy > 32767 || sy + dy < -32768) dy = -dy;
                s = mk(sx, sy, sx + dx, sy + dy, 1);
            end
            s.drain = (i == 120);
            segs_pending.push_back(s);
        end
    end

    // reset
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
    end

    // segment driver
    always @(posedge aclk) begin
        int idle_pct;
        idle_pct = (segs_taken < 90) ? 29 : (segs_taken < 180) ? 52 : 0;
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pixels(seg_on_bus);
                segs_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (segs_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
                    !(segs_pending[0].drain && pixels_due.size() != 0)) begin
                    seg_on_bus = segs_pending.pop_front();
                    s_tdata <= {seg_on_bus.eb, seg_on_bus.eg, seg_on_bus.er,
                                seg_on_bus.sb, seg_on_bus.sg, seg_on_bus.sr,
                                seg_on_bus.ey, seg_on_bus.ex, seg_on_bus.sy,
                                seg_on_bus.sx};
                    s_tvalid <= 1;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // pixel receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        int idle_pct;
        idle_pct = (segs_taken < 90) ? 52 : (segs_taken < 180) ? 29 : 0;
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 0;
        end else if (!hold_done && segs_taken == 40) begin
            hold_done <= 1;
            hold_cnt <= HOLD_LEN;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // pixel monitor
    always @(posedge aclk) begin
        pix_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel word %h last=%b clip=%b",
                             m_tdata, m_tlast, m_tuser);
            end else begin
                e = pixels_due.pop_front();
                if (m_tdata !== {e.b, e.g, e.r, e.y, e.x} || m_tlast !== e.last ||
                    m_tuser !== e.clip) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: exp x=%h y=%h rgb=%h%h%h last=%b clip=%b",
                                 e.x, e.y, e.r, e.g, e.b, e.last, e.clip,
                                 " got x=%h y=%h rgb=%h%h%h last=%b clip=%b",
                                 m_tdata[15:0], m_tdata[31:16], m_tdata[39:32],
                                 m_tdata[47:40], m_tdata[55:48], m_tlast, m_tuser);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("gradient_line_rasterizer_top test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // end of run
    initial begin
        @(posedge aclk);
        while (aresetn !== 1'b1 || segs_pending.size() != 0 || s_tvalid ||
               pixels_due.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pixels_due.size() == 0)
            $display("gradient_line_rasterizer_top test passed");
        else
            $display("gradient_line_rasterizer_top test failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/glr_pkg.sv
rtl/core/glr_datapath.sv
rtl/core/glr_ctrl.sv
rtl/core/gradient_line_rasterizer_top.sv
tb/tb_gradient_line_rasterizer_top.sv
